// File: sv/mesh_xy_route_link_lister_core_defines.svh
// ----------------------------------------------------------------------------
// mesh_xy_route_link_lister_core_defines
// Assertion macros for the XY route link lister. Define ASSERT_OFF to drop
// all checks.
// ----------------------------------------------------------------------------
`ifndef MESH_XY_ROUTE_LINK_LISTER_CORE_DEFINES_SVH
`define MESH_XY_ROUTE_LINK_LISTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MXYRL_ASSERT_IMPL(label_, clk_, rst_n_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_) disable iff (!rst_n_) \
    (ante_) |-> (cons_)) else $error(msg_);
// next-cycle implication
`define MXYRL_ASSERT_NEXT(label_, clk_, rst_n_, ante_, cons_, msg_) \
  label_: assert property (@(posedge clk_) disable iff (!rst_n_) \
    (ante_) |=> (cons_)) else $error(msg_);
`else
`define MXYRL_ASSERT_IMPL(label_, clk_, rst_n_, ante_, cons_, msg_)
`define MXYRL_ASSERT_NEXT(label_, clk_, rst_n_, ante_, cons_, msg_)
`endif

`endif

// File: sv/mxyrl_pkg.sv
// ----------------------------------------------------------------------------
// mxyrl_pkg
// Shared widths, payload structs, controller/datapath command and status
// types for the XY route link lister.
// ----------------------------------------------------------------------------
package mxyrl_pkg;

  // mesh geometry
  localparam int unsigned MaxSide  = 8;
  localparam int unsigned SideW    = 4;
  localparam int unsigned NodeW    = 7;
  localparam int unsigned TagW     = 12;
  localparam int unsigned LinkW    = 7;
  localparam int unsigned CoordW   = 3;
  localparam int unsigned RemW     = 6;
  localparam int unsigned StepW    = 2;
  localparam int unsigned DivSteps = 3;

  localparam logic [SideW-1:0] SideReset = 4'd4;
  localparam logic [SideW-1:0] SideMin   = 4'd2;
  localparam logic [SideW-1:0] SideMax   = SideW'(MaxSide);
  localparam logic [LinkW-1:0] MaxLink   = 7'd111;

  // input request
  typedef struct packed {
    logic [NodeW-1:0] src_node;
    logic [NodeW-1:0] dst_node;
    logic [TagW-1:0]  path_id;
  } req_t;

  // one result
  typedef struct packed {
    logic [LinkW-1:0] link_index;
    logic [TagW-1:0]  path_tag;
    logic             last_link;
    logic             bad_node;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic setup;
    logic advance;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;
    logic same;
    logic div_last;
    logic last;
  } dp_status_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StDiv   = 4'b0010,
    StSetup = 4'b0100,
    StEmit  = 4'b1000
  } ctrl_state_e;

endpackage

// File: sv/mxyrl_ctrl.sv
// ----------------------------------------------------------------------------
// mxyrl_ctrl
// Sequencer: accept a request, run the coordinate divider, set up the walk,
// then hand out one link per output handshake; a bad node skips to one result.
// ----------------------------------------------------------------------------
module mxyrl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mxyrl_pkg::dp_status_t status_i,
  output mxyrl_pkg::dp_cmd_t    cmd_o
);

  mxyrl_pkg::ctrl_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      mxyrl_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mxyrl_pkg::StDiv;
        end
      end
      mxyrl_pkg::StDiv: begin
        if (status_i.bad) begin
          state_d = mxyrl_pkg::StEmit;
        end else if (status_i.same) begin
          state_d = mxyrl_pkg::StIdle;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_last) begin
            state_d = mxyrl_pkg::StSetup;
          end
        end
      end
      mxyrl_pkg::StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = mxyrl_pkg::StEmit;
      end
      mxyrl_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = mxyrl_pkg::StIdle;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = mxyrl_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mxyrl_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/mxyrl_dpath.sv
// ----------------------------------------------------------------------------
// mxyrl_dpath
// Datapath: side register, node range check, shared radix-2 divider for the
// row/column split of both nodes, link base products and the walk counter.
// ----------------------------------------------------------------------------
module mxyrl_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mxyrl_pkg::SideW-1:0]         cfg_data_i,
  input  mxyrl_pkg::req_t                     req_i,
  input  mxyrl_pkg::dp_cmd_t                  cmd_i,
  output mxyrl_pkg::dp_status_t               status_o,
  output mxyrl_pkg::rsp_t                     rsp_o
);

  localparam int unsigned SideW  = mxyrl_pkg::SideW;
  localparam int unsigned CoordW = mxyrl_pkg::CoordW;
  localparam int unsigned RemW   = mxyrl_pkg::RemW;
  localparam int unsigned LinkW  = mxyrl_pkg::LinkW;
  localparam int unsigned NodeW  = mxyrl_pkg::NodeW;
  localparam int unsigned StepW  = mxyrl_pkg::StepW;

  logic [SideW-1:0]   side_q;
  logic [SideW-1:0]   side_eff;
  logic [2*SideW-1:0] side_sq;
  logic [CoordW-1:0]  km1;

  logic               bad_q, same_q;
  logic [mxyrl_pkg::TagW-1:0] tag_q;
  logic [StepW-1:0]   step_q;
  logic [RemW-1:0]    srem_q, drem_q;
  logic [CoordW-1:0]  squo_q, dquo_q;

  logic [CoordW-1:0]  pos_q, hend_q, vlo_q, vend_q;
  logic               vert_q, vempty_q;
  logic [LinkW-1:0]   hbase_q, vbase_q;

  logic               bad_in;
  logic [NodeW-1:0]   src_m1, dst_m1;
  logic [RemW-1:0]    trial;
  logic               s_ge, d_ge;

  logic [CoordW-1:0]      sr, sc, dr, dc, hlo, hhi, vlo, vhi;
  logic [2*CoordW-1:0]    hprod;
  logic [SideW-1:0]       vcol;
  logic [SideW+CoordW-1:0] vprod;

  logic [CoordW-1:0]  pos_nxt;
  logic               h_done, v_done;

  // mesh side register, clamped to the legal range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= mxyrl_pkg::SideReset;
    end else if (cfg_we_i) begin
      side_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (side_q < mxyrl_pkg::SideMin) begin
      side_eff = mxyrl_pkg::SideMin;
    end else if (side_q > mxyrl_pkg::SideMax) begin
      side_eff = mxyrl_pkg::SideMax;
    end else begin
      side_eff = side_q;
    end
  end

  assign side_sq = {{SideW{1'b0}}, side_eff} * {{SideW{1'b0}}, side_eff};
  assign km1     = CoordW'(side_eff - SideW'(1));

  // node range check on the incoming request
  assign bad_in = (req_i.src_node == '0) || ({1'b0, req_i.src_node} > side_sq) ||
                  (req_i.dst_node == '0) || ({1'b0, req_i.dst_node} > side_sq);
  assign src_m1 = req_i.src_node - NodeW'(1);
  assign dst_m1 = req_i.dst_node - NodeW'(1);

  // one quotient bit per step for both nodes
  assign trial = {{(RemW-SideW){1'b0}}, side_eff} << step_q;
  assign s_ge  = (srem_q >= trial);
  assign d_ge  = (drem_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q  <= 1'b0;
      same_q <= 1'b0;
      step_q <= '0;
    end else if (cmd_i.load) begin
      bad_q  <= bad_in;
      same_q <= (req_i.src_node == req_i.dst_node);
      step_q <= StepW'(mxyrl_pkg::DivSteps - 1);
    end else if (cmd_i.div_step) begin
      step_q <= step_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q  <= req_i.path_id;
      srem_q <= src_m1[RemW-1:0];
      drem_q <= dst_m1[RemW-1:0];
      squo_q <= '0;
      dquo_q <= '0;
    end else if (cmd_i.div_step) begin
      srem_q <= s_ge ? (srem_q - trial) : srem_q;
      drem_q <= d_ge ? (drem_q - trial) : drem_q;
      squo_q <= {squo_q[CoordW-2:0], s_ge};
      dquo_q <= {dquo_q[CoordW-2:0], d_ge};
    end
  end

  // route setup: leg bounds and link bases
  assign sr = squo_q;
  assign sc = srem_q[CoordW-1:0];
  assign dr = dquo_q;
  assign dc = drem_q[CoordW-1:0];
  assign hlo = (sc < dc) ? sc : dc;
  assign hhi = (sc < dc) ? dc : sc;
  assign vlo = (sr < dr) ? sr : dr;
  assign vhi = (sr < dr) ? dr : sr;

  assign hprod = {{CoordW{1'b0}}, sr} * {{CoordW{1'b0}}, km1};
  assign vcol  = {1'b0, dc} + side_eff;
  assign vprod = {{CoordW{1'b0}}, vcol} * {{SideW{1'b0}}, km1};

  // walk position
  assign pos_nxt = pos_q + CoordW'(1);
  assign h_done  = (pos_nxt == hend_q);
  assign v_done  = (pos_nxt == vend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q <= 1'b0;
    end else if (cmd_i.setup) begin
      vert_q <= (hlo == hhi);
    end else if (cmd_i.advance && !vert_q && h_done) begin
      vert_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      hbase_q  <= LinkW'(hprod);
      vbase_q  <= LinkW'(vprod);
      hend_q   <= hhi;
      vlo_q    <= vlo;
      vend_q   <= vhi;
      vempty_q <= (vlo == vhi);
      pos_q    <= (hlo != hhi) ? hlo : vlo;
    end else if (cmd_i.advance) begin
      if (!vert_q && h_done) begin
        pos_q <= vlo_q;
      end else begin
        pos_q <= pos_nxt;
      end
    end
  end

  // status back to the sequencer
  assign status_o.bad      = bad_q;
  assign status_o.same     = same_q;
  assign status_o.div_last = (step_q == '0);
  assign status_o.last     = bad_q || (vert_q ? v_done : (h_done && vempty_q));

  // current result
  always_comb begin
    if (bad_q) begin
      rsp_o.link_index = '0;
    end else if (vert_q) begin
      rsp_o.link_index = vbase_q + {{(LinkW-CoordW){1'b0}}, pos_q};
    end else begin
      rsp_o.link_index = hbase_q + {{(LinkW-CoordW){1'b0}}, pos_q};
    end
    rsp_o.path_tag  = tag_q;
    rsp_o.last_link = status_o.last;
    rsp_o.bad_node  = bad_q;
  end

endmodule

// File: sv/mesh_xy_route_link_lister_core.sv
// ----------------------------------------------------------------------------
// mesh_xy_route_link_lister_core
// Lists the links of the XY route between two nodes of a square mesh.
// ----------------------------------------------------------------------------
// Start: the first link is valid after the 3 divider steps and the setup
//   step; a bad node result skips both.
// Flow: one request at a time; the 3-step shared divider sets the startup.
// Equal nodes give no result unless a node is out of range.
// Reset (async, active low) returns to idle with mesh side 4.
`include "mesh_xy_route_link_lister_core_defines.svh"

module mesh_xy_route_link_lister_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mxyrl_pkg::req_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mxyrl_pkg::rsp_t               out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mxyrl_pkg::SideW-1:0]   cfg_data_i
);

  mxyrl_pkg::dp_cmd_t    cmd;
  mxyrl_pkg::dp_status_t status;

  logic                  out_bad;
  logic                  out_last;
  logic                  link_ok;

  // config writes always land
  assign cfg_ready_o = 1'b1;

  mxyrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mxyrl_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .rsp_o      (out_data_o)
  );

  // check terms
  assign out_bad  = out_valid_o && out_data_o.bad_node;
  assign out_last = out_valid_o && out_ready_i && out_data_o.last_link;
  assign link_ok  = (out_data_o.link_index <= mxyrl_pkg::MaxLink);

  // checks
  `MXYRL_ASSERT_IMPL(a_bad_is_single, clk_i, rst_ni, out_bad, out_data_o.last_link, "bad not last")
  `MXYRL_ASSERT_IMPL(a_one_at_a_time, clk_i, rst_ni, in_ready_o, !out_valid_o, "busy overlap")
  `MXYRL_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, out_last, in_ready_o, "no idle after last")
  `MXYRL_ASSERT_IMPL(a_link_range, clk_i, rst_ni, out_valid_o, link_ok, "link out of range")

endmodule
